/* sv/svm_pkg.sv */
package svm_pkg;

    localparam int MEM_BYTES_DEF = 65536;

    localparam logic [15:0] MEM_LIMIT_RST   = 16'hFFF0;
    localparam logic [15:0] STACK_START_RST = 16'h5000;

    // request codes
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_EXEC    = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    // configuration register indexes
    localparam logic CFG_MEM_LIMIT   = 1'b0;
    localparam logic CFG_STACK_START = 1'b1;

    // step status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_HALT   = 3'd1;
    localparam logic [2:0] ST_LIMIT  = 3'd2;
    localparam logic [2:0] ST_BADOP  = 3'd3;
    localparam logic [2:0] ST_BADREG = 3'd4;
    localparam logic [2:0] ST_LOAD   = 3'd5;

    // opcodes
    localparam logic [7:0] OP_NOP      = 8'h00;
    localparam logic [7:0] OP_PUSH     = 8'h10;
    localparam logic [7:0] OP_PUSH_IMM = 8'h11;
    localparam logic [7:0] OP_POP      = 8'h20;
    localparam logic [7:0] OP_ADDI     = 8'h31;
    localparam logic [7:0] OP_SYS      = 8'h40;
    localparam logic [7:0] OP_JMP      = 8'h50;
    localparam logic [7:0] OP_JLT      = 8'h51;
    localparam logic [7:0] OP_JGT      = 8'h52;
    localparam logic [7:0] OP_JEQ      = 8'h53;
    localparam logic [7:0] OP_JNE      = 8'h54;
    localparam logic [7:0] OP_CMP      = 8'h60;
    localparam logic [7:0] OP_CMPI     = 8'h61;
    localparam logic [7:0] OP_ANDI     = 8'h71;
    localparam logic [7:0] OP_ORI      = 8'h81;

    // system call codes
    localparam logic [7:0] SYS_HALT = 8'h00;
    localparam logic [7:0] SYS_PUTC = 8'h01;

    // register index nibbles
    localparam logic [3:0] RI_X0 = 4'd1;
    localparam logic [3:0] RI_X1 = 4'd2;
    localparam logic [3:0] RI_X2 = 4'd3;
    localparam logic [3:0] RI_X3 = 4'd4;
    localparam logic [3:0] RI_SP = 4'd5;
    localparam logic [3:0] RI_BP = 4'd6;
    localparam logic [3:0] RI_PC = 4'd7;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] load_addr;
        logic [7:0]  load_data;
    } svm_req_t;

    typedef struct packed {
        logic        char_valid;
        logic [7:0]  char_code;
        logic [2:0]  status;
        logic [15:0] pc_now;
    } svm_rsp_t;

    // one access of the byte memory
    typedef struct packed {
        logic        we;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } svm_mem_cmd_t;

    // sequencer state seen by the top level
    typedef struct packed {
        logic idle;
        logic done;
    } svm_core_st_t;

endpackage

/* sv/svm_mem.sv */
module svm_mem #(
    parameter int MEM_BYTES = svm_pkg::MEM_BYTES_DEF
) (
    input  logic                  clk,
    input  svm_pkg::svm_mem_cmd_t cmd,
    output logic [7:0]            rdata
);
    import svm_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    logic [7:0]    mem [MEM_BYTES];
    logic [AW-1:0] addr;

    assign addr = cmd.addr[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[addr] <= cmd.wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* sv/svm_core.sv */
module svm_core #(
    parameter int MEM_BYTES = svm_pkg::MEM_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  svm_pkg::svm_req_t     req,
    input  logic [15:0]           mem_limit,
    input  logic [15:0]           stack_start,
    input  logic                  rsp_take,
    output svm_pkg::svm_core_st_t core_st,
    output svm_pkg::svm_rsp_t     rsp,
    output svm_pkg::svm_mem_cmd_t mem_cmd,
    input  logic [7:0]            mem_rdata
);
    import svm_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [AW-1:0] CLR_LAST = AW'(MEM_BYTES - 1);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_OP     = 4'd2;
    localparam logic [3:0] S_B1     = 4'd3;
    localparam logic [3:0] S_PUSHLO = 4'd4;
    localparam logic [3:0] S_POPLO  = 4'd5;
    localparam logic [3:0] S_POPHI  = 4'd6;
    localparam logic [3:0] S_PI1    = 4'd7;
    localparam logic [3:0] S_PI2    = 4'd8;
    localparam logic [3:0] S_PI3    = 4'd9;
    localparam logic [3:0] S_IHI    = 4'd10;
    localparam logic [3:0] S_ILO    = 4'd11;
    localparam logic [3:0] S_IREG   = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [15:0]   pc_reg, pc_next;
    logic [15:0]   sp_reg, sp_next;
    logic [15:0]   bp_reg, bp_next;
    logic [15:0]   x0_reg, x0_next;
    logic [15:0]   x1_reg, x1_next;
    logic [15:0]   x2_reg, x2_next;
    logic [15:0]   x3_reg, x3_next;
    logic          lt_reg, lt_next;
    logic          gt_reg, gt_next;
    logic          halt_reg, halt_next;
    logic [7:0]    op_reg, op_next;
    logic [15:0]   imm_reg, imm_next;
    logic [3:0]    idx_reg, idx_next;
    logic [2:0]    st_reg, st_next;
    logic          chv_reg, chv_next;
    logic [7:0]    chr_reg, chr_next;

    logic [15:0] fetch_addr;
    logic [15:0] rd_lo, rd_hi;
    logic        ok_lo, ok_hi;
    logic        wr_en;
    logic [3:0]  wr_idx;
    logic [15:0] wr_val;
    logic        take;
    logic [15:0] target;

    assign fetch_addr = bp_reg + pc_reg;
    assign target     = {imm_reg[15:8], mem_rdata};

    // register operands named by the byte just read
    always_comb
    begin
        ok_lo = 1'b1;
        unique case (mem_rdata[3:0])
            RI_X0:   rd_lo = x0_reg;
            RI_X1:   rd_lo = x1_reg;
            RI_X2:   rd_lo = x2_reg;
            RI_X3:   rd_lo = x3_reg;
            RI_SP:   rd_lo = sp_reg;
            RI_BP:   rd_lo = bp_reg;
            RI_PC:   rd_lo = pc_reg;
            default:
            begin
                rd_lo = '0;
                ok_lo = 1'b0;
            end
        endcase
        ok_hi = 1'b1;
        unique case (mem_rdata[7:4])
            RI_X0:   rd_hi = x0_reg;
            RI_X1:   rd_hi = x1_reg;
            RI_X2:   rd_hi = x2_reg;
            RI_X3:   rd_hi = x3_reg;
            RI_SP:   rd_hi = sp_reg;
            RI_BP:   rd_hi = bp_reg;
            RI_PC:   rd_hi = pc_reg;
            default:
            begin
                rd_hi = '0;
                ok_hi = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        pc_next    = pc_reg;
        sp_next    = sp_reg;
        bp_next    = bp_reg;
        x0_next    = x0_reg;
        x1_next    = x1_reg;
        x2_next    = x2_reg;
        x3_next    = x3_reg;
        lt_next    = lt_reg;
        gt_next    = gt_reg;
        halt_next  = halt_reg;
        op_next    = op_reg;
        imm_next   = imm_reg;
        idx_next   = idx_reg;
        st_next    = st_reg;
        chv_next   = chv_reg;
        chr_next   = chr_reg;
        mem_cmd    = '0;
        wr_en      = 1'b0;
        wr_idx     = idx_reg;
        wr_val     = '0;
        take       = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_cmd.we   = 1'b1;
                mem_cmd.addr = 16'(clr_reg);
                clr_next     = clr_reg + AW'(1);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    chv_next   = 1'b0;
                    chr_next   = '0;
                    st_next    = ST_LOAD;
                    state_next = S_DONE;
                    unique case (req.req_type)
                        REQ_LOAD:
                        begin
                            mem_cmd.we    = 1'b1;
                            mem_cmd.addr  = req.load_addr;
                            mem_cmd.wdata = req.load_data;
                        end
                        REQ_RESTART:
                        begin
                            x0_next   = '0;
                            x1_next   = '0;
                            x2_next   = '0;
                            x3_next   = '0;
                            bp_next   = '0;
                            pc_next   = '0;
                            sp_next   = stack_start;
                            lt_next   = 1'b0;
                            gt_next   = 1'b0;
                            halt_next = 1'b0;
                        end
                        REQ_EXEC:
                        begin
                            if (halt_reg)
                            begin
                                st_next = ST_HALT;
                            end
                            else if (pc_reg >= mem_limit)
                            begin
                                st_next = ST_LIMIT;
                            end
                            else
                            begin
                                st_next      = ST_OK;
                                mem_cmd.addr = fetch_addr;
                                pc_next      = pc_reg + 16'd1;
                                state_next   = S_OP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_OP:
            begin
                op_next = mem_rdata;
                unique case (mem_rdata) inside
                    OP_NOP:
                    begin
                        state_next = S_DONE;
                    end
                    OP_PUSH, OP_POP, OP_SYS, OP_CMP:
                    begin
                        mem_cmd.addr = fetch_addr;
                        pc_next      = pc_reg + 16'd1;
                        state_next   = S_B1;
                    end
                    OP_PUSH_IMM:
                    begin
                        mem_cmd.addr = fetch_addr;
                        pc_next      = pc_reg + 16'd1;
                        state_next   = S_PI1;
                    end
                    OP_ADDI, OP_CMPI, OP_ANDI, OP_ORI,
                    OP_JMP, OP_JLT, OP_JGT, OP_JEQ, OP_JNE:
                    begin
                        mem_cmd.addr = fetch_addr;
                        pc_next      = pc_reg + 16'd1;
                        state_next   = S_IHI;
                    end
                    default:
                    begin
                        st_next    = ST_BADOP;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_B1:
            begin
                state_next = S_DONE;
                unique case (op_reg)
                    OP_PUSH:
                    begin
                        if (!ok_lo)
                        begin
                            st_next = ST_BADREG;
                        end
                        else
                        begin
                            mem_cmd.we    = 1'b1;
                            mem_cmd.addr  = sp_reg;
                            mem_cmd.wdata = rd_lo[15:8];
                            sp_next       = sp_reg + 16'd1;
                            imm_next      = rd_lo;
                            state_next    = S_PUSHLO;
                        end
                    end
                    OP_POP:
                    begin
                        if (!ok_lo)
                        begin
                            st_next = ST_BADREG;
                        end
                        else
                        begin
                            idx_next     = mem_rdata[3:0];
                            mem_cmd.addr = sp_reg - 16'd1;
                            sp_next      = sp_reg - 16'd1;
                            state_next   = S_POPLO;
                        end
                    end
                    OP_SYS:
                    begin
                        if (mem_rdata == SYS_HALT)
                        begin
                            halt_next = 1'b1;
                            st_next   = ST_HALT;
                        end
                        else if (mem_rdata == SYS_PUTC)
                        begin
                            chv_next = 1'b1;
                            chr_next = x0_reg[7:0];
                        end
                    end
                    OP_CMP:
                    begin
                        if (!ok_lo || !ok_hi)
                        begin
                            st_next = ST_BADREG;
                        end
                        else
                        begin
                            lt_next = rd_hi < rd_lo;
                            gt_next = rd_hi > rd_lo;
                        end
                    end
                    default: ;
                endcase
            end
            S_PUSHLO:
            begin
                mem_cmd.we    = 1'b1;
                mem_cmd.addr  = sp_reg;
                mem_cmd.wdata = imm_reg[7:0];
                sp_next       = sp_reg + 16'd1;
                state_next    = S_DONE;
            end
            S_POPLO:
            begin
                imm_next[7:0] = mem_rdata;
                mem_cmd.addr  = sp_reg - 16'd1;
                sp_next       = sp_reg - 16'd1;
                state_next    = S_POPHI;
            end
            S_POPHI:
            begin
                // register write lands after both stack reads
                wr_en      = 1'b1;
                wr_val     = {mem_rdata, imm_reg[7:0]};
                state_next = S_DONE;
            end
            S_PI1:
            begin
                mem_cmd.we    = 1'b1;
                mem_cmd.addr  = sp_reg;
                mem_cmd.wdata = mem_rdata;
                sp_next       = sp_reg + 16'd1;
                state_next    = S_PI2;
            end
            S_PI2:
            begin
                mem_cmd.addr = fetch_addr;
                pc_next      = pc_reg + 16'd1;
                state_next   = S_PI3;
            end
            S_PI3:
            begin
                mem_cmd.we    = 1'b1;
                mem_cmd.addr  = sp_reg;
                mem_cmd.wdata = mem_rdata;
                sp_next       = sp_reg + 16'd1;
                state_next    = S_DONE;
            end
            S_IHI:
            begin
                imm_next[15:8] = mem_rdata;
                mem_cmd.addr   = fetch_addr;
                pc_next        = pc_reg + 16'd1;
                state_next     = S_ILO;
            end
            S_ILO:
            begin
                unique case (op_reg) inside
                    OP_JMP, OP_JLT, OP_JGT, OP_JEQ, OP_JNE:
                    begin
                        unique case (op_reg)
                            OP_JMP:  take = 1'b1;
                            OP_JLT:  take = lt_reg;
                            OP_JGT:  take = gt_reg;
                            OP_JEQ:  take = !lt_reg && !gt_reg;
                            default: take = lt_reg || gt_reg;
                        endcase
                        if (take)
                        begin
                            pc_next = target;
                            lt_next = 1'b0;
                            gt_next = 1'b0;
                        end
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        imm_next[7:0] = mem_rdata;
                        mem_cmd.addr  = fetch_addr;
                        pc_next       = pc_reg + 16'd1;
                        state_next    = S_IREG;
                    end
                endcase
            end
            S_IREG:
            begin
                state_next = S_DONE;
                wr_idx     = mem_rdata[3:0];
                if (!ok_lo)
                begin
                    st_next = ST_BADREG;
                end
                else
                begin
                    unique case (op_reg)
                        OP_ADDI:
                        begin
                            wr_en  = 1'b1;
                            wr_val = rd_lo + imm_reg;
                        end
                        OP_CMPI:
                        begin
                            lt_next = rd_lo < imm_reg;
                            gt_next = rd_lo > imm_reg;
                        end
                        OP_ANDI:
                        begin
                            wr_en  = 1'b1;
                            wr_val = rd_lo & imm_reg;
                        end
                        default:
                        begin
                            wr_en  = 1'b1;
                            wr_val = rd_lo | imm_reg;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                if (rsp_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register file write, wins over pointer steps of the same cycle
        if (wr_en)
        begin
            unique case (wr_idx)
                RI_X0:   x0_next = wr_val;
                RI_X1:   x1_next = wr_val;
                RI_X2:   x2_next = wr_val;
                RI_X3:   x3_next = wr_val;
                RI_SP:   sp_next = wr_val;
                RI_BP:   bp_next = wr_val;
                RI_PC:   pc_next = wr_val;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            pc_reg    <= '0;
            sp_reg    <= '0;
            bp_reg    <= '0;
            x0_reg    <= '0;
            x1_reg    <= '0;
            x2_reg    <= '0;
            x3_reg    <= '0;
            lt_reg    <= 1'b0;
            gt_reg    <= 1'b0;
            halt_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pc_reg    <= pc_next;
            sp_reg    <= sp_next;
            bp_reg    <= bp_next;
            x0_reg    <= x0_next;
            x1_reg    <= x1_next;
            x2_reg    <= x2_next;
            x3_reg    <= x3_next;
            lt_reg    <= lt_next;
            gt_reg    <= gt_next;
            halt_reg  <= halt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        imm_reg <= imm_next;
        idx_reg <= idx_next;
        st_reg  <= st_next;
        chv_reg <= chv_next;
        chr_reg <= chr_next;
    end

    assign core_st.idle = (state_reg == S_IDLE);
    assign core_st.done = (state_reg == S_DONE);

    assign rsp.char_valid = chv_reg;
    assign rsp.char_code  = chr_reg;
    assign rsp.status     = st_reg;
    assign rsp.pc_now     = pc_reg;

endmodule

/* sv/stack_vm_instruction_step.sv */
// Small 16-bit stack machine. Each request word loads one program byte, restarts the
// registers, or executes one instruction (request code 3 does nothing); every request
// gives exactly one response word. Program and stack share one byte memory of MEM_BYTES
// entries (a power of two; addresses are taken modulo its size) with a single port and a
// registered read, so the cost of a request is set by its memory accesses done one per
// cycle. A load, restart or refused execute goes straight to handing its result to the
// output register; an executed instruction reads its opcode byte and then its operand
// bytes, with PUSH, POP and PUSHI adding stack accesses (PUSH and POP naming a bad
// register stop after the register byte). The next request also waits while the output
// register stays stalled with an earlier word. A new request is taken as soon as the
// previous result sits in the output register. After reset a clearing pass writes zero
// to every memory byte, during which req_stall is high; configuration writes are taken
// at any time (cfg_ready is always 1).
module stack_vm_instruction_step #(
    parameter int MEM_BYTES = svm_pkg::MEM_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              req_valid,
    output logic              req_stall,
    input  svm_pkg::svm_req_t req_word,
    // response channel
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output svm_pkg::svm_rsp_t rsp_word,
    // configuration writes
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_data
);
    import svm_pkg::*;

    logic [15:0]  mem_limit_reg, mem_limit_next;
    logic [15:0]  stack_start_reg, stack_start_next;
    logic         rsp_valid_reg, rsp_valid_next;
    svm_rsp_t     rsp_word_reg;

    svm_core_st_t core_st;
    svm_rsp_t     core_rsp;
    svm_mem_cmd_t mem_cmd;
    logic [7:0]   mem_rdata;
    logic         start;
    logic         rsp_take;

    // a word is only taken while the sequencer sits idle
    assign req_stall = !core_st.idle;
    assign start     = req_valid && core_st.idle;

    // result moves to the output register once that register is free or draining
    assign rsp_take = core_st.done && (!rsp_valid_reg || !rsp_stall);

    assign cfg_ready = 1'b1;

    always_comb
    begin
        mem_limit_next   = mem_limit_reg;
        stack_start_next = stack_start_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MEM_LIMIT:   mem_limit_next   = cfg_data;
                CFG_STACK_START: stack_start_next = cfg_data;
                default: ;
            endcase
        end

        rsp_valid_next = rsp_valid_reg;
        if (rsp_take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_limit_reg   <= MEM_LIMIT_RST;
            stack_start_reg <= STACK_START_RST;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            mem_limit_reg   <= mem_limit_next;
            stack_start_reg <= stack_start_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // output payload, held while stalled
    always_ff @(posedge clk)
    begin
        if (rsp_take)
        begin
            rsp_word_reg <= core_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    svm_core #(
        .MEM_BYTES (MEM_BYTES)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .req         (req_word),
        .mem_limit   (mem_limit_reg),
        .stack_start (stack_start_reg),
        .rsp_take    (rsp_take),
        .core_st     (core_st),
        .rsp         (core_rsp),
        .mem_cmd     (mem_cmd),
        .mem_rdata   (mem_rdata)
    );

    svm_mem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_mem (
        .clk   (clk),
        .cmd   (mem_cmd),
        .rdata (mem_rdata)
    );

endmodule
